>>> rtl/core/gesture_debounce_fsm_macros.svh
// ----------------------------------------------------------------------------
// gesture_debounce_fsm_macros.svh
// Assertion macros for the gesture debounce block. Each macro samples on clk
// and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GESTURE_DEBOUNCE_FSM_MACROS_SVH
`define GESTURE_DEBOUNCE_FSM_MACROS_SVH

// Same-cycle implication
`define GDF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gdf_pkg.sv
// ----------------------------------------------------------------------------
// gdf_pkg
// Shared types and constants of the gesture debounce block: gesture codes,
// message codes, configuration register indexes and the control/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gdf_pkg;

    // Gesture classes
    typedef logic [1:0] gesture_t;
    localparam gesture_t G_NONE    = 2'd0;
    localparam gesture_t G_PRESS   = 2'd1;
    localparam gesture_t G_MOVE    = 2'd2;
    localparam gesture_t G_ENLARGE = 2'd3;

    // Mode codes as seen on the result
    typedef logic [1:0] mode_code_t;
    localparam mode_code_t MODE_CODE_NOHAND = 2'd0;
    localparam mode_code_t MODE_CODE_READY  = 2'd1;
    localparam mode_code_t MODE_CODE_ACTION = 2'd2;
    localparam mode_code_t MODE_CODE_PAUSED = 2'd3;

    // Status message codes
    typedef logic [2:0] msg_t;
    localparam msg_t MSG_BLANK        = 3'd0;
    localparam msg_t MSG_PLACE_HAND   = 3'd1;
    localparam msg_t MSG_RECOG_HANDS  = 3'd2;
    localparam msg_t MSG_RECOG_GEST   = 3'd3;
    localparam msg_t MSG_PAUSED       = 3'd4;
    localparam msg_t MSG_IN_ACTION    = 3'd5;

    // Configuration registers
    localparam int unsigned NUM_CFG = 5;
    localparam int unsigned CFG_W   = 6;
    typedef logic [CFG_W-1:0] cfg_t;
    typedef logic [2:0]       cfg_idx_t;
    localparam cfg_idx_t CFG_HAND_RECOG   = 3'd0;
    localparam cfg_idx_t CFG_GEST_RECOG   = 3'd1;
    localparam cfg_idx_t CFG_HAND_LOST    = 3'd2;
    localparam cfg_idx_t CFG_PAUSE        = 3'd3;
    localparam cfg_idx_t CFG_ACTION_CHG   = 3'd4;
    localparam cfg_t CFG_RESET [NUM_CFG] = '{6'd10, 6'd10, 6'd4, 6'd5, 6'd3};

    // Progress scale: percent, fits in SCALE_W bits
    localparam int unsigned PERCENT_SCALE = 100;
    localparam int unsigned SCALE_W       = 7;
    localparam int unsigned PROG_W        = 8;

    // Frame counter operation
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_CLR  = 2'd2
    } count_op_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       eval;
        count_op_t  count_op;
        logic       prev_load;
        logic       held_load;
        logic       msg_load;
        msg_t       msg;
        logic       sw_load;
        logic       sw_value;
        cfg_idx_t   lim_sel;
        logic       div_start;
        gesture_t   judged;
        logic       fault;
        logic       out_load;
        mode_code_t mode_code;
    } gdf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        gesture_t             raw;
        gesture_t             prev;
        gesture_t             held;
        logic [NUM_CFG-1:0]   over;
        logic                 div_done;
        logic                 out_free;
    } gdf_status_t;

endpackage

`default_nettype wire

>>> rtl/core/gdf_datapath.sv
// ----------------------------------------------------------------------------
// gdf_datapath
// Frame counter, gesture history, configuration registers, a restoring
// divider for the progress percentage and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gesture_debounce_fsm_macros.svh"

module gdf_datapath #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gdf_pkg::gdf_cmd_t   cmd,
    output gdf_pkg::gdf_status_t     st,
    input  wire gdf_pkg::gesture_t   raw_gesture,
    input  wire logic                cfg_we,
    input  wire gdf_pkg::cfg_idx_t   cfg_index,
    input  wire gdf_pkg::cfg_t       cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gdf_pkg::gesture_t        judged_gesture,
    output gdf_pkg::mode_code_t      mode_now,
    output logic [gdf_pkg::PROG_W-1:0] progress_percent,
    output gdf_pkg::msg_t            status_message,
    output logic                     action_switched,
    output logic                     fault
);
    import gdf_pkg::*;

    localparam int unsigned DW   = COUNT_WIDTH + SCALE_W;
    localparam int unsigned IT_W = $clog2(DW);

    cfg_t                   cfg_reg [NUM_CFG];
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [NUM_CFG-1:0]     limit_over;
    gesture_t               raw_reg;
    gesture_t               prev_reg;
    gesture_t               held_reg;
    msg_t                   msg_reg;
    logic                   sw_reg;
    logic [PROG_W-1:0]      progress_reg;
    gesture_t               judged_reg;
    logic                   fault_reg;

    logic [DW-1:0]          quo_reg;
    logic [CFG_W-1:0]       rem_reg;
    cfg_t                   div_lim_reg;
    logic [IT_W-1:0]        it_reg;
    logic                   div_busy_reg;
    logic [CFG_W:0]         rem_shift;
    logic [CFG_W:0]         rem_diff;
    logic                   qbit;
    logic [DW-1:0]          quo_final;
    logic                   div_last;
    logic [PROG_W-1:0]      progress_sat;

    logic                   out_valid_reg;
    gesture_t               judged_out_reg;
    mode_code_t             mode_out_reg;
    logic [PROG_W-1:0]      progress_out_reg;
    msg_t                   msg_out_reg;
    logic                   sw_out_reg;
    logic                   fault_out_reg;

    // Saturating frame count for this frame
    assign count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                           : count_reg + 1'b1;

    // One compare per limit register
    always_comb
    begin
        for (int i = 0; i < NUM_CFG; i++)
        begin
            limit_over[i] = count_inc > COUNT_WIDTH'(cfg_reg[i]);
        end
    end

    // Divider step: shift one dividend bit into the remainder. A zero limit
    // makes every quotient bit one, so the result saturates to full scale.
    assign rem_shift    = {rem_reg, quo_reg[DW-1]};
    assign rem_diff     = rem_shift - {1'b0, div_lim_reg};
    assign qbit         = rem_shift >= {1'b0, div_lim_reg};
    assign quo_final    = {quo_reg[DW-2:0], qbit};
    assign div_last     = div_busy_reg && (it_reg == IT_W'(DW - 1));
    assign progress_sat = (|quo_final[DW-1:PROG_W]) ? {PROG_W{1'b1}}
                                                     : quo_final[PROG_W-1:0];

    // Status toward the controller
    assign st = '{raw:      raw_reg,
                  prev:     prev_reg,
                  held:     held_reg,
                  over:     limit_over,
                  div_done: div_last,
                  out_free: !out_valid_reg || out_ready};

    // Configuration and per-frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
            count_reg    <= '0;
            prev_reg     <= G_NONE;
            held_reg     <= G_PRESS;
            msg_reg      <= MSG_BLANK;
            sw_reg       <= 1'b0;
            progress_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < cfg_idx_t'(NUM_CFG)))
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            case (cmd.count_op)
                CNT_INC: count_reg <= count_inc;
                CNT_CLR: count_reg <= '0;
                default: count_reg <= count_reg;
            endcase
            if (cmd.prev_load)
            begin
                prev_reg <= raw_reg;
            end
            if (cmd.held_load)
            begin
                held_reg <= raw_reg;
            end
            if (cmd.msg_load)
            begin
                msg_reg <= cmd.msg;
            end
            if (cmd.sw_load)
            begin
                sw_reg <= cmd.sw_value;
            end
            if (div_last)
            begin
                progress_reg <= progress_sat;
            end
        end
    end

    // Divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            it_reg       <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            it_reg       <= '0;
        end
        else if (div_busy_reg)
        begin
            div_busy_reg <= !div_last;
            it_reg       <= it_reg + 1'b1;
        end
    end

    // Captured item, step results and divider operands
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg <= raw_gesture;
        end
        if (cmd.eval)
        begin
            judged_reg <= cmd.judged;
            fault_reg  <= cmd.fault;
        end
        if (cmd.div_start)
        begin
            quo_reg     <= DW'(count_inc) * DW'(PERCENT_SCALE);
            rem_reg     <= '0;
            div_lim_reg <= cfg_reg[cmd.lim_sel];
        end
        else if (div_busy_reg)
        begin
            quo_reg <= quo_final;
            rem_reg <= qbit ? rem_diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            judged_out_reg   <= judged_reg;
            mode_out_reg     <= cmd.mode_code;
            progress_out_reg <= progress_reg;
            msg_out_reg      <= msg_reg;
            sw_out_reg       <= sw_reg;
            fault_out_reg    <= fault_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign judged_gesture   = judged_out_reg;
    assign mode_now         = mode_out_reg;
    assign progress_percent = progress_out_reg;
    assign status_message   = msg_out_reg;
    assign action_switched  = sw_out_reg;
    assign fault            = fault_out_reg;

    `GDF_ASSERT_NEXT(a_progress_hold, !div_last, $stable(progress_reg), "progress moved")
    `GDF_ASSERT_IMPLY(a_no_load_while_full, cmd.out_load, st.out_free, "result overwritten")

endmodule

`default_nettype wire

>>> rtl/core/gdf_ctrl.sv
// ----------------------------------------------------------------------------
// gdf_ctrl
// Sequencer (idle, evaluate, divide, done) and the four-mode gesture machine.
// Decides every state update of a frame and drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gesture_debounce_fsm_macros.svh"

module gdf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire gdf_pkg::gdf_status_t  st,
    output gdf_pkg::gdf_cmd_t          cmd
);
    import gdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } seq_state_t;

    typedef enum logic [3:0] {
        MODE_NOHAND = 4'b0001,
        MODE_READY  = 4'b0010,
        MODE_ACTION = 4'b0100,
        MODE_PAUSED = 4'b1000
    } mode_t;

    seq_state_t state_reg;
    seq_state_t state_next;
    mode_t      mode_reg;
    mode_t      mode_next;
    mode_t      adv_mode;
    logic       same;
    logic       adv;
    logic       held_on_adv;
    logic       sw_on_adv;

    function automatic mode_code_t mode_code(input mode_t m);
        case (m)
            MODE_READY:  return MODE_CODE_READY;
            MODE_ACTION: return MODE_CODE_ACTION;
            MODE_PAUSED: return MODE_CODE_PAUSED;
            default:     return MODE_CODE_NOHAND;
        endcase
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign same     = (st.raw == st.prev);

    // Frame decision
    always_comb
    begin
        cmd           = '0;
        cmd.count_op  = CNT_HOLD;
        cmd.lim_sel   = CFG_HAND_RECOG;
        cmd.msg       = MSG_BLANK;
        cmd.judged    = st.raw;
        cmd.mode_code = mode_code(mode_reg);
        cmd.capture   = (state_reg == S_IDLE) && in_valid;
        cmd.out_load  = (state_reg == S_DONE) && st.out_free;
        mode_next     = mode_reg;
        adv_mode      = mode_reg;
        adv           = 1'b0;
        held_on_adv   = 1'b0;
        sw_on_adv     = 1'b0;

        if (state_reg == S_EVAL)
        begin
            cmd.eval = 1'b1;
            if (same)
            begin
                // Repeated gesture: count it and test the active limit where the mode sets one
                cmd.count_op = CNT_INC;
                case (mode_reg)
                    MODE_NOHAND:
                    begin
                        if (st.raw == G_NONE)
                        begin
                            cmd.msg_load = 1'b1;
                            cmd.msg      = MSG_PLACE_HAND;
                        end
                        else if (st.raw == G_MOVE)
                        begin
                            cmd.msg_load = 1'b1;
                            cmd.msg      = MSG_RECOG_HANDS;
                            adv          = 1'b1;
                            cmd.lim_sel  = CFG_HAND_RECOG;
                            adv_mode     = MODE_READY;
                        end
                        else
                        begin
                            // press or enlarge cannot repeat without a hand
                            cmd.fault = 1'b1;
                        end
                    end
                    MODE_READY:
                    begin
                        cmd.msg_load = 1'b1;
                        cmd.msg      = MSG_RECOG_GEST;
                        adv          = 1'b1;
                        if (st.raw == G_NONE)
                        begin
                            cmd.lim_sel = CFG_HAND_LOST;
                            adv_mode    = MODE_NOHAND;
                        end
                        else
                        begin
                            cmd.lim_sel = CFG_GEST_RECOG;
                            adv_mode    = MODE_ACTION;
                            held_on_adv = 1'b1;
                        end
                    end
                    MODE_PAUSED:
                    begin
                        cmd.msg_load = 1'b1;
                        cmd.msg      = MSG_PAUSED;
                        cmd.lim_sel  = CFG_PAUSE;
                        case (st.raw)
                            G_PRESS:
                            begin
                                adv         = 1'b1;
                                adv_mode    = MODE_ACTION;
                                held_on_adv = 1'b1;
                            end
                            G_MOVE:
                            begin
                                adv      = 1'b1;
                                adv_mode = MODE_READY;
                            end
                            G_NONE:
                            begin
                                adv      = 1'b1;
                                adv_mode = MODE_NOHAND;
                            end
                            default:
                            begin
                                // enlarge is ignored while paused
                                adv = 1'b0;
                            end
                        endcase
                    end
                    MODE_ACTION:
                    begin
                        cmd.msg_load = 1'b1;
                        cmd.msg      = MSG_IN_ACTION;
                        if (st.raw == G_NONE)
                        begin
                            adv         = 1'b1;
                            cmd.lim_sel = CFG_HAND_LOST;
                            adv_mode    = MODE_NOHAND;
                        end
                        else
                        begin
                            cmd.sw_load  = 1'b1;
                            cmd.sw_value = 1'b0;
                            cmd.judged   = st.held;
                            if (st.raw != st.held)
                            begin
                                adv         = 1'b1;
                                cmd.lim_sel = CFG_ACTION_CHG;
                                adv_mode    = (st.held == G_PRESS) ? MODE_PAUSED
                                                                   : MODE_READY;
                                sw_on_adv   = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        adv = 1'b0;
                    end
                endcase

                // Progress whenever a limit is tested; mode change once the limit is passed
                if (adv)
                begin
                    cmd.div_start = 1'b1;
                    if (st.over[cmd.lim_sel])
                    begin
                        mode_next     = adv_mode;
                        cmd.count_op  = CNT_CLR;
                        cmd.held_load = held_on_adv;
                        if (sw_on_adv)
                        begin
                            cmd.sw_value = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // New gesture: restart the count where the mode allows it
                case (mode_reg)
                    MODE_NOHAND:
                    begin
                        if ((st.raw == G_PRESS) || (st.raw == G_ENLARGE))
                        begin
                            cmd.judged = st.prev;
                        end
                        else
                        begin
                            cmd.count_op  = CNT_CLR;
                            cmd.prev_load = 1'b1;
                        end
                    end
                    MODE_READY:
                    begin
                        if (st.raw != G_NONE)
                        begin
                            cmd.count_op  = CNT_CLR;
                            cmd.prev_load = 1'b1;
                        end
                    end
                    MODE_ACTION:
                    begin
                        cmd.count_op  = CNT_CLR;
                        cmd.prev_load = 1'b1;
                        if (st.raw != G_NONE)
                        begin
                            cmd.judged = st.held;
                        end
                    end
                    MODE_PAUSED:
                    begin
                        if (st.raw != G_ENLARGE)
                        begin
                            cmd.count_op  = CNT_CLR;
                            cmd.prev_load = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.count_op = CNT_HOLD;
                    end
                endcase
            end
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = cmd.div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_NOHAND;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    `GDF_ASSERT_NEXT(a_accept_eval, in_valid && in_ready, state_reg == S_EVAL, "accepted item skipped evaluation")
    `GDF_ASSERT_NEXT(a_mode_hold, state_reg != S_EVAL, $stable(mode_reg), "mode changed outside evaluation")
    `GDF_ASSERT_IMPLY(a_div_in_div, st.div_done, state_reg == S_DIV, "divider finished outside divide state")

endmodule

`default_nettype wire

>>> rtl/core/gesture_debounce_fsm.sv
// An accepted item passes from idle through evaluate, divide when a frame limit
// is tested, and done, which loads it into the result register once it is free.
// Items are taken one at a time, in the idle state only; the bit-serial percentage
// divider takes one quotient bit per cycle.
// A new item is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; limits return to 10, 10, 4, 5, 3.
// ----------------------------------------------------------------------------
// gesture_debounce_fsm
// Per-frame gesture qualifier: four-mode debounce machine with progress
// percentage, status message, action-switch flag and fault flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gesture_debounce_fsm #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire gdf_pkg::gesture_t     raw_gesture,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gdf_pkg::gesture_t          judged_gesture,
    output gdf_pkg::mode_code_t        mode_now,
    output logic [gdf_pkg::PROG_W-1:0] progress_percent,
    output gdf_pkg::msg_t              status_message,
    output logic                       action_switched,
    output logic                       fault,
    input  wire logic                  cfg_we,
    input  wire gdf_pkg::cfg_idx_t     cfg_index,
    input  wire gdf_pkg::cfg_t         cfg_data
);
    import gdf_pkg::*;

    gdf_cmd_t    cmd;
    gdf_status_t st;

    // Sequencer and mode machine
    gdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Counters, limits, divider and result register
    gdf_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .raw_gesture      (raw_gesture),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .judged_gesture   (judged_gesture),
        .mode_now         (mode_now),
        .progress_percent (progress_percent),
        .status_message   (status_message),
        .action_switched  (action_switched),
        .fault            (fault)
    );

endmodule

`default_nettype wire

>>> tb/gesture_debounce_fsm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_debounce_fsm_test
// Self-checking bench for the per-frame gesture qualifier. A short table of
// frames walks the mode machine through each mode, zero and lowered limits,
// the ignored register index and the enlarge repeat while paused. Random runs
// of steady gestures follow, under changing frame limits. A model of the
// machine predicts each result not typed in the table; both handshakes idle at random.
// ----------------------------------------------------------------------------

module gesture_debounce_fsm_test;

    import gdf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 1150;
    localparam int HOLD_RUN    = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int PLAN_ROWS   = 29;
    localparam logic [7:0] COUNT_TOP = 8'hFF;

    typedef struct packed {
        gesture_t          judged;
        mode_code_t        mode;
        logic [PROG_W-1:0] percent;
        msg_t              message;
        logic              switched;
        logic              flt;
    } frame_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        gesture_t      g;
        cfg_idx_t      idx;
        cfg_t          val;
        logic          typed;
        frame_result_t want;
    } plan_row_t;

    // Directed frames; rows with typed set carry their own result
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_ITEM, G_NONE, '0, '0, 1'b1,
            '{G_NONE, MODE_CODE_NOHAND, 8'd0, MSG_PLACE_HAND, 1'b0, 1'b0}},
        '{ROW_ITEM, G_ENLARGE, '0, '0, 1'b1,
            '{G_NONE, MODE_CODE_NOHAND, 8'd0, MSG_PLACE_HAND, 1'b0, 1'b0}},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b1,
            '{G_NONE, MODE_CODE_NOHAND, 8'd0, MSG_PLACE_HAND, 1'b0, 1'b0}},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b1,
            '{G_MOVE, MODE_CODE_NOHAND, 8'd0, MSG_PLACE_HAND, 1'b0, 1'b0}},
        '{ROW_CFG, G_NONE, CFG_HAND_RECOG, 6'd1, 1'b0, '0},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b1,
            '{G_MOVE, MODE_CODE_READY, 8'd200, MSG_RECOG_HANDS, 1'b0, 1'b0}},
        '{ROW_CFG, G_NONE, CFG_GEST_RECOG, 6'd0, 1'b0, '0},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b1,
            '{G_PRESS, MODE_CODE_ACTION, 8'd255, MSG_RECOG_GEST, 1'b0, 1'b0}},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b0, '0},
        '{ROW_CFG, G_NONE, CFG_ACTION_CHG, 6'd1, 1'b0, '0},
        '{ROW_ITEM, G_ENLARGE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_ENLARGE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_ENLARGE, '0, '0, 1'b1,
            '{G_PRESS, MODE_CODE_PAUSED, 8'd200, MSG_IN_ACTION, 1'b1, 1'b0}},
        '{ROW_ITEM, G_ENLARGE, '0, '0, 1'b1,
            '{G_ENLARGE, MODE_CODE_PAUSED, 8'd200, MSG_PAUSED, 1'b1, 1'b0}},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b0, '0},
        '{ROW_CFG, G_NONE, CFG_PAUSE, 6'd2, 1'b0, '0},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_MOVE, '0, '0, 1'b0, '0},
        '{ROW_CFG, G_NONE, cfg_idx_t'(NUM_CFG), 6'd63, 1'b0, '0},
        '{ROW_CFG, G_NONE, CFG_HAND_LOST, 6'd1, 1'b0, '0},
        '{ROW_ITEM, G_NONE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_PRESS, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_NONE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_NONE, '0, '0, 1'b0, '0},
        '{ROW_ITEM, G_NONE, '0, '0, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    gesture_t          raw_gesture = G_NONE;
    logic              out_valid;
    logic              out_ready = 1'b0;
    gesture_t          judged_gesture;
    mode_code_t        mode_now;
    logic [PROG_W-1:0] progress_percent;
    msg_t              status_message;
    logic              action_switched;
    logic              fault;
    logic              cfg_we = 1'b0;
    cfg_idx_t          cfg_index = '0;
    cfg_t              cfg_data = '0;

    // Model of the mode machine
    cfg_t              lim [NUM_CFG];
    mode_code_t        st_mode;
    logic [7:0]        frame_cnt;
    gesture_t          last_g;
    gesture_t          held_g;
    logic [7:0]        percent_q;
    msg_t              message_q;
    logic              switched_q;

    frame_result_t     verdicts [$];
    frame_result_t     got_r;
    frame_result_t     want_r;
    int                items_sent = 0;
    int                results_seen = 0;
    int                mismatches = 0;
    int                rx_wait = 0;
    int                quiet = 0;
    bit                calm = 1'b0;

    gesture_debounce_fsm dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .raw_gesture      (raw_gesture),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .judged_gesture   (judged_gesture),
        .mode_now         (mode_now),
        .progress_percent (progress_percent),
        .status_message   (status_message),
        .action_switched  (action_switched),
        .fault            (fault),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Update progress and move the mode once the count exceeds the limit
    function automatic logic count_reached(input cfg_t limit_v, input mode_code_t next_mode);
        int q;
        if (limit_v == '0)
            percent_q = 8'd255;
        else
        begin
            q = int'(frame_cnt) * PERCENT_SCALE / int'(limit_v);
            percent_q = (q > 255) ? 8'd255 : 8'(q);
        end
        if (frame_cnt > 8'(limit_v))
        begin
            st_mode = next_mode;
            frame_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the model by one frame and form its result
    task automatic qualify_frame(input gesture_t g, output frame_result_t r);
        gesture_t   judged;
        logic       flt;
        mode_code_t next_mode;
        judged = g;
        flt = 1'b0;
        if (g == last_g)
        begin
            if (frame_cnt != COUNT_TOP)
                frame_cnt++;
            case (st_mode)
                MODE_CODE_NOHAND:
                begin
                    if (g == G_NONE)
                        message_q = MSG_PLACE_HAND;
                    else if (g == G_MOVE)
                    begin
                        message_q = MSG_RECOG_HANDS;
                        void'(count_reached(lim[CFG_HAND_RECOG], MODE_CODE_READY));
                    end
                    else
                        flt = 1'b1;
                end
                MODE_CODE_READY:
                begin
                    message_q = MSG_RECOG_GEST;
                    if (g == G_NONE)
                        void'(count_reached(lim[CFG_HAND_LOST], MODE_CODE_NOHAND));
                    else if (count_reached(lim[CFG_GEST_RECOG], MODE_CODE_ACTION))
                        held_g = g;
                end
                MODE_CODE_PAUSED:
                begin
                    message_q = MSG_PAUSED;
                    if (g == G_PRESS)
                    begin
                        if (count_reached(lim[CFG_PAUSE], MODE_CODE_ACTION))
                            held_g = g;
                    end
                    else if (g == G_MOVE)
                        void'(count_reached(lim[CFG_PAUSE], MODE_CODE_READY));
                    else if (g == G_NONE)
                        void'(count_reached(lim[CFG_PAUSE], MODE_CODE_NOHAND));
                end
                default:
                begin
                    message_q = MSG_IN_ACTION;
                    if (g == G_NONE)
                        void'(count_reached(lim[CFG_HAND_LOST], MODE_CODE_NOHAND));
                    else
                    begin
                        switched_q = 1'b0;
                        if (g != held_g)
                        begin
                            next_mode = (held_g == G_PRESS) ? MODE_CODE_PAUSED : MODE_CODE_READY;
                            if (count_reached(lim[CFG_ACTION_CHG], next_mode))
                                switched_q = 1'b1;
                        end
                        judged = held_g;
                    end
                end
            endcase
        end
        else
        begin
            case (st_mode)
                MODE_CODE_NOHAND:
                begin
                    // press or enlarge cannot start a hand; answer the last gesture
                    if (g == G_PRESS || g == G_ENLARGE)
                        judged = last_g;
                    else
                    begin
                        frame_cnt = '0;
                        last_g = g;
                    end
                end
                MODE_CODE_READY:
                begin
                    if (g != G_NONE)
                    begin
                        frame_cnt = '0;
                        last_g = g;
                    end
                end
                MODE_CODE_ACTION:
                begin
                    frame_cnt = '0;
                    last_g = g;
                    if (g != G_NONE)
                        judged = held_g;
                end
                default:
                begin
                    // enlarge is not handled while paused
                    if (g != G_ENLARGE)
                    begin
                        frame_cnt = '0;
                        last_g = g;
                    end
                end
            endcase
        end
        r = '{judged, st_mode, percent_q, message_q, switched_q, flt};
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t: %s", $time, what);
    endtask

    // Offer one frame after a random gap and hold it until taken
    task automatic send_item(input gesture_t g, input logic typed, input frame_result_t want);
        int            gap;
        frame_result_t r;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_gesture <= g;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        qualify_frame(g, r);
        if (typed)
            r = want;
        verdicts = {verdicts, r};
        items_sent++;
    endtask

    // Drop valid and hold until every frame has been answered
    task automatic settle();
        in_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input cfg_idx_t idx, input cfg_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx < NUM_CFG)
            lim[idx] = val;
    endtask

    // Take results with random stalls and check them in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_r = '{judged_gesture, mode_now, progress_percent, status_message,
                          action_switched, fault};
                results_seen++;
                if (verdicts.size() == 0)
                    note_mismatch($sformatf("result %0d arrived with no frame pending",
                                            results_seen));
                else
                begin
                    want_r = verdicts.pop_front();
                    if (got_r.judged !== want_r.judged)
                        note_mismatch($sformatf("result %0d judged_gesture %0d, want %0d",
                                                results_seen, got_r.judged, want_r.judged));
                    if (got_r.mode !== want_r.mode)
                        note_mismatch($sformatf("result %0d mode_now %0d, want %0d",
                                                results_seen, got_r.mode, want_r.mode));
                    if (got_r.percent !== want_r.percent)
                        note_mismatch($sformatf("result %0d progress_percent %0d, want %0d",
                                                results_seen, got_r.percent, want_r.percent));
                    if (got_r.message !== want_r.message)
                        note_mismatch($sformatf("result %0d status_message %0d, want %0d",
                                                results_seen, got_r.message, want_r.message));
                    if (got_r.switched !== want_r.switched)
                        note_mismatch($sformatf("result %0d action_switched %0d, want %0d",
                                                results_seen, got_r.switched, want_r.switched));
                    if (got_r.flt !== want_r.flt)
                        note_mismatch($sformatf("result %0d fault %0d, want %0d",
                                                results_seen, got_r.flt, want_r.flt));
                end
                rx_wait = calm ? 0 : $urandom_range(0, 3);
                out_ready <= (rx_wait == 0);
            end
            else if (!out_ready)
            begin
                if (rx_wait > 1)
                    rx_wait--;
                else
                begin
                    rx_wait = 0;
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // End the run when no handshake completes for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int         i;
        int         k;
        int         sel;
        int         run;
        int         top;
        int         phase_end;
        cfg_t       val;
        gesture_t   g;

        for (i = 0; i < NUM_CFG; i++)
            lim[i] = CFG_RESET[i];
        st_mode = MODE_CODE_NOHAND;
        frame_cnt = '0;
        last_g = G_NONE;
        held_g = G_PRESS;
        percent_q = '0;
        message_q = MSG_BLANK;
        switched_q = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                settle();
                write_limit(PLAN[i].idx, PLAN[i].val);
            end
            else
                send_item(PLAN[i].g, PLAN[i].typed, PLAN[i].want);
        end

        // Hold no hand long enough to saturate the frame counter
        settle();
        calm = 1'b1;
        repeat (HOLD_RUN) send_item(G_NONE, 1'b0, '0);

        // Random runs of steady gestures under fresh limits per phase
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            top = 1;
            for (k = 0; k < NUM_CFG; k++)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:          val = '0;
                    1:          val = '1;
                    2:          val = 6'd1;
                    3, 4, 5, 6: val = cfg_t'($urandom_range(2, 6));
                    default:    val = cfg_t'($urandom_range(1, 63));
                endcase
                write_limit(cfg_idx_t'(k), val);
                if (int'(val) > top)
                    top = int'(val);
            end
            if ($urandom_range(0, 2) == 0)
                write_limit(cfg_idx_t'($urandom_range(NUM_CFG, 7)), cfg_t'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(40, 120);
            if (phase_end > ITEM_TARGET)
                phase_end = ITEM_TARGET;
            while (items_sent < phase_end)
            begin
                g = gesture_t'($urandom_range(0, 3));
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    run = 1;
                else if (sel == 1)
                    run = $urandom_range(1, 3);
                else
                    run = $urandom_range(1, top + 2);
                repeat (run) send_item(g, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/gdf_pkg.sv
rtl/core/gdf_datapath.sv
rtl/core/gdf_ctrl.sv
rtl/core/gesture_debounce_fsm.sv
tb/gesture_debounce_fsm_test.sv
